// ===== sv/mec_pkg.sv =====
// Shared types, constants and colour functions for the Mandelbrot escape-time block.
`timescale 1ns / 1ps

package mec_pkg;

    localparam int FRAC_BITS = 28;
    localparam int COORD_W   = 32;
    localparam int ITER_W    = 16;
    localparam int RADIUS_W  = 31;
    localparam int LEVEL_W   = 10;
    localparam int DIV_STEPS = LEVEL_W;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 2 * COORD_W;
    localparam int OUT_PAD_W = 7;
    localparam int OUT_DATA_W = ITER_W + 1 + 24 + OUT_PAD_W;

    localparam logic [ITER_W-1:0] LIMIT_RESET = 16'd256;
    localparam logic [63:0]       PROD_LIMIT  = 64'h4000_0000_0000_0000;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ESC_RADIUS = 1'b1;

    // Gradient segments
    localparam logic [1:0] SEG_DARK_BLUE = 2'd0;
    localparam logic [1:0] SEG_BLUE_CYAN = 2'd1;
    localparam logic [1:0] SEG_CYAN_YEL  = 2'd2;
    localparam logic [1:0] SEG_YEL_ORNG  = 2'd3;

    localparam logic [7:0]  COLOUR_BASE = 8'd64;
    localparam logic [7:0]  COLOUR_FULL = 8'd255;
    localparam logic [15:0] SCALE_NUM   = 16'd191;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic load;
        logic mul_en;
        logic sum_en;
        logic step_en;
        logic div_start;
        logic div_step;
        logic colour_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic limit_zero;
        logic escaped;
        logic last_iter;
    } dp_stat_t;

    typedef struct packed {
        dp_stat_t dp;
        logic     div_last;
        logic     out_free;
    } stat_t;

    // floor(u * 191 / 255); reciprocal form exact for products below 2^16
    function automatic logic [7:0] scale_191(input logic [7:0] u);
        logic [15:0] v;
        logic [16:0] t;
        v = 16'(u) * SCALE_NUM;
        t = 17'(v) + 17'(v >> 8) + 17'd1;
        return t[15:8];
    endfunction

    function automatic rgb_t level_colour(input logic [LEVEL_W-1:0] level);
        rgb_t       c;
        logic [7:0] u;
        logic [7:0] s;
        u = level[7:0];
        s = scale_191(u);
        c = '0;
        case (level[LEVEL_W-1:8])
            SEG_DARK_BLUE: begin
                c.blue = COLOUR_BASE + s;
            end
            SEG_BLUE_CYAN: begin
                c.green = u;
                c.blue  = COLOUR_FULL;
            end
            SEG_CYAN_YEL: begin
                c.red   = u;
                c.green = COLOUR_FULL;
                c.blue  = COLOUR_FULL - u;
            end
            default: begin
                c.red   = COLOUR_FULL;
                c.green = COLOUR_FULL - s;
            end
        endcase
        return c;
    endfunction

endpackage

// ===== sv/mandelbrot_escape_color.sv =====
// Top level of the Mandelbrot escape-time colour block.
`timescale 1ns / 1ps

// Evaluates one point c = c_real + i*c_imag (signed, FRAC_BITS fraction bits) per
// request and returns its escape count, an inside flag and an RGB gradient colour.
// One point is in flight at a time; a new request is taken as soon as the previous
// result sits in the output register. Each z = z^2 + c iteration runs a split
// partial-product multiply, product sum and shift, then escape test and update.
// A point that escapes also goes through a restoring divide for the colour level
// before its result is loaded into the output register.

module mandelbrot_escape_color
#(
    parameter int FRAC_BITS = mec_pkg::FRAC_BITS
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mec_pkg::IN_DATA_W-1:0]       s_tdata,   // c_real, c_imag
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mec_pkg::OUT_DATA_W-1:0]      m_tdata,   // escape_count, inside_set, red,
                                                           // green, blue, zero pad
    input  logic                                cfg_wr_en,
    input  logic [mec_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mec_pkg::RADIUS_W-1:0]        cfg_wdata
);

    localparam logic [mec_pkg::RADIUS_W-1:0] RADIUS_RESET =
        mec_pkg::RADIUS_W'(64'd2 << FRAC_BITS);

    logic [mec_pkg::ITER_W-1:0]         limit_reg;
    logic [mec_pkg::RADIUS_W-1:0]       radius_reg;
    logic                               m_tvalid_reg;
    logic [mec_pkg::OUT_DATA_W-1:0]     m_tdata_reg;

    mec_pkg::cmd_t                      cmd;
    mec_pkg::stat_t                     stat;
    mec_pkg::dp_stat_t                  dp_stat;
    mec_pkg::rgb_t                      rgb;
    logic                               div_last;
    logic [mec_pkg::ITER_W-1:0]         iter;
    logic [mec_pkg::ITER_W-1:0]         escape_count;
    logic                               inside_set;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg  <= mec_pkg::LIMIT_RESET;
            radius_reg <= RADIUS_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                mec_pkg::REG_ITER_LIMIT: limit_reg  <= cfg_wdata[mec_pkg::ITER_W-1:0];
                mec_pkg::REG_ESC_RADIUS: radius_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign stat.dp       = dp_stat;
    assign stat.div_last = div_last;
    assign stat.out_free = !m_tvalid_reg || m_tready;

    mec_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mec_dp #(.FRAC_BITS(FRAC_BITS)) u_dp
    (
        .clk          (clk),
        .cmd          (cmd),
        .limit        (limit_reg),
        .radius       (radius_reg),
        .c_real       ($signed(s_tdata[mec_pkg::COORD_W-1:0])),
        .c_imag       ($signed(s_tdata[mec_pkg::IN_DATA_W-1:mec_pkg::COORD_W])),
        .iter         (iter),
        .escape_count (escape_count),
        .inside_set   (inside_set),
        .stat         (dp_stat)
    );

    mec_level u_level
    (
        .clk      (clk),
        .cmd      (cmd),
        .count    (iter),
        .limit    (limit_reg),
        .rgb      (rgb),
        .div_last (div_last)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            m_tdata_reg <= {{mec_pkg::OUT_PAD_W{1'b0}}, rgb.blue, rgb.green, rgb.red,
                            inside_set, escape_count};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== sv/mec_ctrl.sv =====
// Controller state machine sequencing load, iteration, level division and output.
`timescale 1ns / 1ps

module mec_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mec_pkg::stat_t  stat,
    output mec_pkg::cmd_t   cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MUL    = 3'd1;
    localparam logic [2:0] S_SUM    = 3'd2;
    localparam logic [2:0] S_STEP   = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_COLOUR = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.dp.limit_zero ? S_DONE : S_MUL;
                end
            end
            S_MUL:
            begin
                cmd.mul_en = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum_en = 1'b1;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                cmd.step_en = 1'b1;
                if (stat.dp.escaped)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
                else if (stat.dp.last_iter)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_MUL;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_COLOUR;
                end
            end
            S_COLOUR:
            begin
                cmd.colour_en = 1'b1;
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/mec_dp.sv =====
// Iteration datapath: split partial-product multipliers, product sums, escape test, z update.
`timescale 1ns / 1ps

module mec_dp
#(
    parameter int FRAC_BITS = mec_pkg::FRAC_BITS
)
(
    input  logic                                  clk,
    input  mec_pkg::cmd_t                         cmd,
    input  logic [mec_pkg::ITER_W-1:0]            limit,
    input  logic [mec_pkg::RADIUS_W-1:0]          radius,
    input  logic signed [mec_pkg::COORD_W-1:0]    c_real,
    input  logic signed [mec_pkg::COORD_W-1:0]    c_imag,
    output logic [mec_pkg::ITER_W-1:0]            iter,
    output logic [mec_pkg::ITER_W-1:0]            escape_count,
    output logic                                  inside_set,
    output mec_pkg::dp_stat_t                     stat
);

    localparam int S    = FRAC_BITS + 12;
    localparam int LW   = (S + 1) / 2;
    localparam int HW   = S - LW;
    localparam int WIDE = (2 * S > 64) ? 2 * S : 64;
    localparam int R2W  = 2 * mec_pkg::RADIUS_W - FRAC_BITS;
    localparam logic signed [WIDE-1:0] PROD_LIM = $signed(WIDE'(mec_pkg::PROD_LIMIT));

    logic signed [S-1:0]                   x_reg, y_reg;
    logic signed [mec_pkg::COORD_W-1:0]    cr_reg, ci_reg;
    logic [R2W-1:0]                        r2_reg;
    logic [mec_pkg::ITER_W-1:0]            it_reg, count_reg;
    logic                                  inside_reg;

    logic [2*LW-1:0]                       xx_ll_reg, yy_ll_reg, xy_ll_reg;
    logic signed [HW+LW:0]                 xx_hl_reg, yy_hl_reg, xy_hl_reg, xy_lh_reg;
    logic signed [2*HW-1:0]                xx_hh_reg, yy_hh_reg, xy_hh_reg;
    logic signed [63:0]                    x2_reg, y2_reg, xy_reg;

    logic [LW-1:0]                         x_lo, y_lo;
    logic signed [HW-1:0]                  x_hi, y_hi;
    logic [2*mec_pkg::RADIUS_W-1:0]        r_sq;
    logic [63:0]                           mag_sum;
    logic signed [63:0]                    x_wide, y_wide;
    logic                                  escaped;

    function automatic logic signed [WIDE-1:0] combine(
        input logic [2*LW-1:0]        ll,
        input logic signed [HW+LW:0]  a,
        input logic signed [HW+LW:0]  b,
        input logic signed [2*HW-1:0] hh
    );
        logic signed [WIDE-1:0] s;
        s = ($signed(WIDE'(hh)) <<< (2 * LW))
          + (($signed(WIDE'(a)) + $signed(WIDE'(b))) <<< LW)
          + $signed(WIDE'(ll));
        return s;
    endfunction

    // floor(p / 2^sh), saturated at +-2^62
    function automatic logic signed [63:0] scale_sat(
        input logic signed [WIDE-1:0] p,
        input int                     sh
    );
        logic signed [WIDE-1:0] q;
        q = p >>> sh;
        if (q > PROD_LIM)
        begin
            q = PROD_LIM;
        end
        else if (q < -PROD_LIM)
        begin
            q = -PROD_LIM;
        end
        return q[63:0];
    endfunction

    assign x_lo = x_reg[LW-1:0];
    assign y_lo = y_reg[LW-1:0];
    assign x_hi = x_reg[S-1:LW];
    assign y_hi = y_reg[S-1:LW];
    assign r_sq = radius * radius;

    assign mag_sum = {1'b0, x2_reg[62:0]} + {1'b0, y2_reg[62:0]};
    assign escaped = mag_sum > 64'(r2_reg);
    assign x_wide  = x2_reg - y2_reg + 64'(cr_reg);
    assign y_wide  = xy_reg + 64'(ci_reg);

    assign stat.limit_zero = (limit == '0);
    assign stat.escaped    = escaped;
    assign stat.last_iter  = (({1'b0, it_reg} + 17'd1) == {1'b0, limit});

    assign iter         = it_reg;
    assign escape_count = count_reg;
    assign inside_set   = inside_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            cr_reg     <= c_real;
            ci_reg     <= c_imag;
            r2_reg     <= r_sq[2*mec_pkg::RADIUS_W-1:FRAC_BITS];
            it_reg     <= '0;
            count_reg  <= limit;
            inside_reg <= 1'b1;
        end
        else if (cmd.step_en)
        begin
            if (escaped)
            begin
                count_reg  <= it_reg;
                inside_reg <= 1'b0;
            end
            else
            begin
                x_reg  <= x_wide[S-1:0];
                y_reg  <= y_wide[S-1:0];
                it_reg <= it_reg + 16'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            xx_ll_reg <= x_lo * x_lo;
            xx_hl_reg <= x_hi * $signed({1'b0, x_lo});
            xx_hh_reg <= x_hi * x_hi;
            yy_ll_reg <= y_lo * y_lo;
            yy_hl_reg <= y_hi * $signed({1'b0, y_lo});
            yy_hh_reg <= y_hi * y_hi;
            xy_ll_reg <= x_lo * y_lo;
            xy_hl_reg <= x_hi * $signed({1'b0, y_lo});
            xy_lh_reg <= y_hi * $signed({1'b0, x_lo});
            xy_hh_reg <= x_hi * y_hi;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x2_reg <= '0;
            y2_reg <= '0;
            xy_reg <= '0;
        end
        else if (cmd.sum_en)
        begin
            x2_reg <= scale_sat(combine(xx_ll_reg, xx_hl_reg, xx_hl_reg, xx_hh_reg), FRAC_BITS);
            y2_reg <= scale_sat(combine(yy_ll_reg, yy_hl_reg, yy_hl_reg, yy_hh_reg), FRAC_BITS);
            xy_reg <= scale_sat(combine(xy_ll_reg, xy_hl_reg, xy_lh_reg, xy_hh_reg),
                                FRAC_BITS - 1);
        end
    end

endmodule

// ===== sv/mec_level.sv =====
// Level divider (one quotient bit a cycle) and gradient colour register.
`timescale 1ns / 1ps

module mec_level
(
    input  logic                          clk,
    input  mec_pkg::cmd_t                 cmd,
    input  logic [mec_pkg::ITER_W-1:0]    count,
    input  logic [mec_pkg::ITER_W-1:0]    limit,
    output mec_pkg::rgb_t                 rgb,
    output logic                          div_last
);

    localparam int STEP_W = $clog2(mec_pkg::DIV_STEPS);

    logic [mec_pkg::ITER_W-1:0]   rem_reg;
    logic [mec_pkg::LEVEL_W-1:0]  quo_reg;
    logic [STEP_W-1:0]            step_reg;
    mec_pkg::rgb_t                rgb_reg;

    logic [mec_pkg::ITER_W:0]     rem_dbl;
    logic                         fits;

    // count < limit, so the remainder stays below the limit
    assign rem_dbl  = {rem_reg, 1'b0};
    assign fits     = rem_dbl >= {1'b0, limit};
    assign div_last = (step_reg == STEP_W'(mec_pkg::DIV_STEPS - 1));
    assign rgb      = rgb_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg  <= count;
            quo_reg  <= '0;
            step_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg  <= fits ? rem_dbl[mec_pkg::ITER_W-1:0] - limit
                             : rem_dbl[mec_pkg::ITER_W-1:0];
            quo_reg  <= {quo_reg[mec_pkg::LEVEL_W-2:0], fits};
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rgb_reg <= '0;
        end
        else if (cmd.colour_en)
        begin
            rgb_reg <= mec_pkg::level_colour(quo_reg);
        end
    end

endmodule
